// ===== rtl/spgcd_pkg.sv =====
`default_nettype none
package spgcd_pkg;

    // rotation count of every cordic run
    localparam int CORDIC_STEPS = 24;
    localparam int CNT_W        = 6;

    // fixed-point constants, angles in q30 radians
    localparam logic signed [35:0] ANG_PI      = 36'sd3373259426;
    localparam logic signed [35:0] ANG_HALF_PI = 36'sd1686629713;
    localparam logic signed [35:0] ANG_TWO_PI  = 36'sd6746518852;
    localparam logic signed [35:0] GAIN_INV    = 36'sd652032874;
    localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
    localparam logic [30:0]        CONV_MUL    = 31'd1686629713;
    localparam logic [29:0]        CONV_DIV    = 30'd900000000;
    // floor(2^32 * CONV_MUL / CONV_DIV), estimate is at most one below
    localparam logic [32:0]        CONV_RECIP  = 33'd8048910508;
    localparam logic [30:0]        DIAM_CM     = 31'd1274200000;
    localparam logic [30:0]        DIST_MAX    = 31'h7fffffff;

    // datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
    localparam logic [OP_W-1:0] OP_CMUL    = 5'd2;
    localparam logic [OP_W-1:0] OP_DIV     = 5'd3;
    localparam logic [OP_W-1:0] OP_DEND    = 5'd4;
    localparam logic [OP_W-1:0] OP_SCLD    = 5'd5;
    localparam logic [OP_W-1:0] OP_SCRED   = 5'd6;
    localparam logic [OP_W-1:0] OP_SCFOLD  = 5'd7;
    localparam logic [OP_W-1:0] OP_SCSTEP  = 5'd8;
    localparam logic [OP_W-1:0] OP_SCEND   = 5'd9;
    localparam logic [OP_W-1:0] OP_M1      = 5'd10;
    localparam logic [OP_W-1:0] OP_M2      = 5'd11;
    localparam logic [OP_W-1:0] OP_M3      = 5'd12;
    localparam logic [OP_W-1:0] OP_M4      = 5'd13;
    localparam logic [OP_W-1:0] OP_SQ      = 5'd14;
    localparam logic [OP_W-1:0] OP_ATI     = 5'd15;
    localparam logic [OP_W-1:0] OP_AT      = 5'd16;
    localparam logic [OP_W-1:0] OP_DMUL    = 5'd17;
    localparam logic [OP_W-1:0] OP_DFIN    = 5'd18;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [1:0]       sel;
        logic [CNT_W-1:0] step;
    } t_cmd;

    // atan(2^-i) in q30
    function automatic logic [29:0] f_step_angle(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd843314856;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043836;
            5'd3:    v = 30'd133525158;
            5'd4:    v = 30'd67021686;
            5'd5:    v = 30'd33543515;
            5'd6:    v = 30'd16775850;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194282;
            5'd9:    v = 30'd2097149;
            5'd31:   v = 30'd0;
            default: v = 30'd1 << (5'd30 - i);
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/successive_point_great_circle_distance.sv =====
// great-circle distance between successive points
//
// input channel (s_axis): one request per point, latitude and longitude in
// units of 1e-7 degree. output channel (m_axis): distance in centimetres
// from the previous point, saturating at the top of its range.
// the first point after reset only primes the stored point and gives no
// result; every later point gives exactly one.
// one point is in work at a time. a point that gives a result raises
// m_axis_tvalid once its work is done, and the input is ready again in the
// same cycle; the last step waits while an older result is not yet taken.
// the work runs as two coordinate conversions (reciprocal multiply,
// back-multiply, correction), four sine/cosine cordic runs, the haversine
// multiplies, a 32-step square root, a cordic vectoring run and final
// scaling. the first point leaves the input ready again once both of its
// coordinates are converted. the cordic unit is shared by all its runs.
// the result waits in an output register; a new point is accepted while it
// waits, and the next result is held back until the register is taken.
// reset (synchronous, active low) drops the stored point and any result.
`default_nettype none
module successive_point_great_circle_distance (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [30:0] latitude, [62:31] longitude, [63] zero
    input  wire  [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [30:0] distance_cm, [31] zero
    output logic [31:0] m_axis_tdata
);
    import spgcd_pkg::*;

    t_cmd        w_cmd;
    logic [30:0] w_dist;

    spgcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    spgcd_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .i_latitude    ($signed(s_axis_tdata[30:0])),
        .i_longitude   ($signed(s_axis_tdata[62:31])),
        .o_distance_cm (w_dist)
    );

    assign m_axis_tdata = {1'b0, w_dist};

endmodule
`default_nettype wire

// ===== rtl/spgcd_ctrl.sv =====
`default_nettype none
module spgcd_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output spgcd_pkg::t_cmd   o_cmd
);
    import spgcd_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CMUL   = 5'd1;
    localparam logic [4:0] S_DIV    = 5'd2;
    localparam logic [4:0] S_DEND   = 5'd3;
    localparam logic [4:0] S_SCLD   = 5'd4;
    localparam logic [4:0] S_SCRED  = 5'd5;
    localparam logic [4:0] S_SCFOLD = 5'd6;
    localparam logic [4:0] S_SCSTEP = 5'd7;
    localparam logic [4:0] S_SCEND  = 5'd8;
    localparam logic [4:0] S_M1     = 5'd9;
    localparam logic [4:0] S_M2     = 5'd10;
    localparam logic [4:0] S_M3     = 5'd11;
    localparam logic [4:0] S_M4     = 5'd12;
    localparam logic [4:0] S_SQ     = 5'd13;
    localparam logic [4:0] S_ATI    = 5'd14;
    localparam logic [4:0] S_AT     = 5'd15;
    localparam logic [4:0] S_DMUL   = 5'd16;
    localparam logic [4:0] S_DFIN   = 5'd17;

    localparam logic [CNT_W-1:0] CNT_CORDIC = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] CNT_SQRT   = CNT_W'(31);

    logic [4:0]       r_state, n_state;
    logic [1:0]       r_sel, n_sel;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_had, n_had;
    logic             r_have_prev, n_have_prev;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_fin;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = o_in_ready && i_in_valid;
    assign w_fin       = (r_state == S_DFIN) && (!r_out_valid || i_out_ready);

    // sequencing of the whole computation
    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_cnt       = r_cnt;
        n_had       = r_had;
        n_have_prev = r_have_prev;
        n_out_valid = r_out_valid;
        o_cmd.op    = OP_NONE;
        o_cmd.sel   = r_sel;
        o_cmd.step  = r_cnt;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.op    = OP_LOAD;
                    n_had       = r_have_prev;
                    n_have_prev = 1'b1;
                    n_sel       = 2'd0;
                    n_state     = S_CMUL;
                end
            end
            S_CMUL: begin
                o_cmd.op = OP_CMUL;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                n_state  = S_DEND;
            end
            S_DEND: begin
                o_cmd.op = OP_DEND;
                if (r_sel == 2'd0) begin
                    n_sel   = 2'd1;
                    n_state = S_CMUL;
                end else if (r_had) begin
                    n_sel   = 2'd0;
                    n_state = S_SCLD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCLD: begin
                o_cmd.op = OP_SCLD;
                n_state  = S_SCRED;
            end
            S_SCRED: begin
                o_cmd.op = OP_SCRED;
                n_state  = S_SCFOLD;
            end
            S_SCFOLD: begin
                o_cmd.op = OP_SCFOLD;
                n_cnt    = '0;
                n_state  = S_SCSTEP;
            end
            S_SCSTEP: begin
                o_cmd.op = OP_SCSTEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_CORDIC) begin
                    n_state = S_SCEND;
                end
            end
            S_SCEND: begin
                o_cmd.op = OP_SCEND;
                n_sel    = r_sel + 1'b1;
                n_state  = (r_sel == 2'd3) ? S_M1 : S_SCLD;
            end
            S_M1: begin
                o_cmd.op = OP_M1;
                n_state  = S_M2;
            end
            S_M2: begin
                o_cmd.op = OP_M2;
                n_state  = S_M3;
            end
            S_M3: begin
                o_cmd.op = OP_M3;
                n_state  = S_M4;
            end
            S_M4: begin
                o_cmd.op = OP_M4;
                n_cnt    = '0;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_SQRT) begin
                    n_state = S_ATI;
                end
            end
            S_ATI: begin
                o_cmd.op = OP_ATI;
                n_cnt    = '0;
                n_state  = S_AT;
            end
            S_AT: begin
                o_cmd.op = OP_AT;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_CORDIC) begin
                    n_state = S_DMUL;
                end
            end
            S_DMUL: begin
                o_cmd.op = OP_DMUL;
                n_state  = S_DFIN;
            end
            S_DFIN: begin
                if (w_fin) begin
                    o_cmd.op    = OP_DFIN;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= 2'd0;
            r_cnt       <= '0;
            r_had       <= 1'b0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_cnt       <= n_cnt;
            r_had       <= n_had;
            r_have_prev <= n_have_prev;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/spgcd_dp.sv =====
`default_nettype none
module spgcd_dp (
    input  wire                i_clk,
    input  spgcd_pkg::t_cmd    i_cmd,
    input  wire signed [30:0]  i_latitude,
    input  wire signed [31:0]  i_longitude,
    output logic [30:0]        o_distance_cm
);
    import spgcd_pkg::*;

    // clamp to the q30 unit range
    function automatic logic signed [31:0] f_clamp1(input logic signed [35:0] v);
        logic signed [35:0] c;
        c = (v > ONE_Q30) ? ONE_Q30 : ((v < -ONE_Q30) ? -ONE_Q30 : v);
        return c[31:0];
    endfunction

    logic signed [30:0] r_lat_raw;
    logic signed [31:0] r_lon_raw;
    logic signed [35:0] r_ang_lat, r_ang_lon, r_ang_lat_p, r_ang_lon_p;
    logic [61:0]        r_prod;
    logic               r_csign;
    logic [32:0]        r_q;
    logic [61:0]        r_qd;
    logic signed [35:0] r_x, r_y, r_z;
    logic               r_neg;
    logic signed [31:0] r_c1, r_c2, r_s1, r_s2;
    logic signed [63:0] r_p, r_sq;
    logic [63:0]        r_n1, r_n2, r_res1, r_res2;
    logic [61:0]        r_dp;
    logic [30:0]        r_dist;

    logic [4:0]         w_i;
    logic signed [32:0] w_coord, w_mag33;
    logic [31:0]        w_mag;
    logic [64:0]        w_est;
    logic [61:0]        w_rem_d;
    logic               w_ge;
    logic [32:0]        w_q_fix;
    logic signed [35:0] w_q_s;
    logic signed [35:0] w_theta;
    logic signed [35:0] w_step_ang;
    logic signed [35:0] w_xs, w_ys;
    logic signed [35:0] w_xf, w_yf;
    logic signed [31:0] w_cl_x, w_cl_y;
    logic signed [63:0] w_m_cc, w_m_ss, w_m_cs, w_m_ts;
    logic signed [31:0] w_c12, w_t;
    logic signed [63:0] w_a_sum, w_a;
    logic [5:0]         w_sq_sh;
    logic [63:0]        w_bit, w_try1, w_try2;
    logic signed [35:0] w_h;
    logic [30:0]        w_h_u;
    logic [62:0]        w_round;
    logic [32:0]        w_dsh;

    assign w_i        = i_cmd.step[4:0];
    assign w_step_ang = 36'(f_step_angle(w_i));
    assign w_xs       = r_x >>> w_i;
    assign w_ys       = r_y >>> w_i;

    // magnitude of the coordinate being converted and its quotient estimate
    always_comb begin
        w_coord = i_cmd.sel[0] ? 33'(r_lon_raw) : 33'(r_lat_raw);
        w_mag33 = (w_coord < 0) ? -w_coord : w_coord;
        w_mag   = w_mag33[31:0];
        w_est   = {33'd0, w_mag} * {32'd0, CONV_RECIP};
    end

    // correction of the reciprocal quotient estimate
    always_comb begin
        w_rem_d = r_prod - r_qd;
        w_ge    = (w_rem_d >= {32'd0, CONV_DIV});
        w_q_fix = r_q + {32'd0, w_ge};
        w_q_s   = r_csign ? -$signed({3'b000, w_q_fix}) : $signed({3'b000, w_q_fix});
    end

    // angle fed to the sine/cosine run
    always_comb begin
        case (i_cmd.sel)
            2'd0:    w_theta = r_ang_lat_p;
            2'd1:    w_theta = r_ang_lat;
            2'd2:    w_theta = (r_ang_lat - r_ang_lat_p) >>> 1;
            default: w_theta = (r_ang_lon - r_ang_lon_p) >>> 1;
        endcase
    end

    // sign fix and clamp of the rotation result
    always_comb begin
        w_xf   = r_neg ? -r_x : r_x;
        w_yf   = r_neg ? -r_y : r_y;
        w_cl_x = f_clamp1(w_xf);
        w_cl_y = f_clamp1(w_yf);
    end

    // products of the haversine term
    always_comb begin
        w_m_cc  = r_c1 * r_c2;
        w_m_ss  = r_s1 * r_s1;
        w_c12   = 32'(r_p >>> 30);
        w_m_cs  = w_c12 * r_s2;
        w_t     = 32'(r_p >>> 30);
        w_m_ts  = w_t * r_s2;
        w_a_sum = r_sq + r_p;
        w_a     = (w_a_sum < 0) ? 64'sd0 :
                  ((w_a_sum > (64'sd1 <<< 60)) ? (64'sd1 <<< 60) : w_a_sum);
    end

    // square root step on both lanes
    always_comb begin
        w_sq_sh = 6'd62 - {i_cmd.step[4:0], 1'b0};
        w_bit   = 64'd1 << w_sq_sh;
        w_try1  = r_res1 + w_bit;
        w_try2  = r_res2 + w_bit;
    end

    // half angle clamp and distance rounding
    always_comb begin
        w_h     = (r_z < 0) ? 36'sd0 : ((r_z > ANG_HALF_PI) ? ANG_HALF_PI : r_z);
        w_h_u   = w_h[30:0];
        w_round = {1'b0, r_dp} + (63'd1 << 29);
        w_dsh   = w_round[62:30];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_lat_raw   <= i_latitude;
                r_lon_raw   <= i_longitude;
                r_ang_lat_p <= r_ang_lat;
                r_ang_lon_p <= r_ang_lon;
            end
            OP_CMUL: begin
                r_prod  <= 62'(w_mag * CONV_MUL);
                r_q     <= w_est[64:32];
                r_csign <= (w_coord < 0);
            end
            OP_DIV: begin
                r_qd <= 62'(r_q * CONV_DIV);
            end
            OP_DEND: begin
                if (i_cmd.sel[0]) begin
                    r_ang_lon <= w_q_s;
                end else begin
                    r_ang_lat <= w_q_s;
                end
            end
            OP_SCLD: begin
                r_z <= w_theta;
            end
            OP_SCRED: begin
                if (r_z > ANG_PI) begin
                    r_z <= r_z - ANG_TWO_PI;
                end else if (r_z <= -ANG_PI) begin
                    r_z <= r_z + ANG_TWO_PI;
                end
            end
            OP_SCFOLD: begin
                r_x <= GAIN_INV;
                r_y <= '0;
                if (r_z > ANG_HALF_PI) begin
                    r_z   <= r_z - ANG_PI;
                    r_neg <= 1'b1;
                end else if (r_z < -ANG_HALF_PI) begin
                    r_z   <= r_z + ANG_PI;
                    r_neg <= 1'b1;
                end else begin
                    r_neg <= 1'b0;
                end
            end
            OP_SCSTEP: begin
                if (r_z >= 0) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_step_ang;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_step_ang;
                end
            end
            OP_SCEND: begin
                case (i_cmd.sel)
                    2'd0:    r_c1 <= w_cl_x;
                    2'd1:    r_c2 <= w_cl_x;
                    2'd2:    r_s1 <= (w_cl_y < 0) ? -w_cl_y : w_cl_y;
                    default: r_s2 <= (w_cl_y < 0) ? -w_cl_y : w_cl_y;
                endcase
            end
            OP_M1: begin
                r_p  <= w_m_cc;
                r_sq <= w_m_ss;
            end
            OP_M2: begin
                r_p <= w_m_cs;
            end
            OP_M3: begin
                r_p <= w_m_ts;
            end
            OP_M4: begin
                r_n1   <= w_a;
                r_n2   <= (64'd1 << 60) - w_a;
                r_res1 <= '0;
                r_res2 <= '0;
            end
            OP_SQ: begin
                if (r_n1 >= w_try1) begin
                    r_n1   <= r_n1 - w_try1;
                    r_res1 <= (r_res1 >> 1) + w_bit;
                end else begin
                    r_res1 <= r_res1 >> 1;
                end
                if (r_n2 >= w_try2) begin
                    r_n2   <= r_n2 - w_try2;
                    r_res2 <= (r_res2 >> 1) + w_bit;
                end else begin
                    r_res2 <= r_res2 >> 1;
                end
            end
            OP_ATI: begin
                r_y <= $signed({1'b0, r_res1[34:0]});
                r_x <= $signed({1'b0, r_res2[34:0]});
                r_z <= '0;
            end
            OP_AT: begin
                if (r_y > 0) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_step_ang;
                end else if (r_y < 0) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_step_ang;
                end
            end
            OP_DMUL: begin
                r_dp <= 62'(w_h_u * DIAM_CM);
            end
            OP_DFIN: begin
                r_dist <= (w_dsh > {2'b00, DIST_MAX}) ? DIST_MAX : w_dsh[30:0];
            end
            default: begin
            end
        endcase
    end

    assign o_distance_cm = r_dist;

endmodule
`default_nettype wire

// ===== tb/sv/successive_point_great_circle_distance_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

// haversine distance predictor and result store
class distance_scoreboard;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint RADIUS_CM   = 64'sd637100000;
    localparam longint DIST_SAT    = 64'sd2147483647;

    longint atan_tab[32] = '{843314856, 497837829, 263043836, 133525158, 67021686,
        33543515, 16775850, 8388437, 4194282, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
        32, 16, 8, 4, 2, 1, 0};

    logic signed [30:0] last_lat;
    logic signed [31:0] last_lon;
    bit                 last_valid;
    logic [30:0]        pending_dist[$];
    int                 mismatches;
    int                 results_seen;
    int                 points_seen;

    function new();
        last_lat     = '0;
        last_lon     = '0;
        last_valid   = 0;
        mismatches   = 0;
        results_seen = 0;
        points_seen  = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint coord_to_rad(longint c);
        return (c * PI_Q30) / 64'sd1800000000;
    endfunction

    // rotation cordic with quadrant fold
    function void rotate(longint theta, output longint c, output longint s);
        longint r, x, y, nx;
        bit     flip;
        r = theta % TWO_PI_Q30;
        x = GAIN_Q30;
        y = 0;
        flip = 0;
        if (r < 0) r += TWO_PI_Q30;
        if (r > PI_Q30) r -= TWO_PI_Q30;
        if (r > HALF_PI_Q30) begin
            r -= PI_Q30;
            flip = 1;
        end else if (r < -HALF_PI_Q30) begin
            r += PI_Q30;
            flip = 1;
        end
        for (int i = 0; i < spgcd_pkg::CORDIC_STEPS && i < 32; i++) begin
            if (r >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                r -= atan_tab[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                r += atan_tab[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clip(x, -ONE_Q30, ONE_Q30);
        s = clip(y, -ONE_Q30, ONE_Q30);
    endfunction

    // vectoring cordic, first quadrant angle
    function longint vector_angle(longint y, longint x);
        longint z, nx;
        z = 0;
        for (int i = 0; i < spgcd_pkg::CORDIC_STEPS && i < 32; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += atan_tab[i];
            end else if (y < 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= atan_tab[i];
            end else begin
                nx = x;
            end
            x = nx;
        end
        return clip(z, 0, HALF_PI_Q30);
    endfunction

    function longint int_root(longint unsigned n);
        longint unsigned root, b;
        root = 0;
        for (int k = 0; k < 32; k++) begin
            b = 64'd1 << (62 - 2 * k);
            if (n >= root + b) begin
                n -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
        end
        return longint'(root);
    endfunction

    // accepted point request: update stored point, predict distance
    function void note_point(logic signed [30:0] lat, logic signed [31:0] lon);
        longint r1, r2, dlat, dlon, c1, c2, junk, s1, s2, c12, t, a, h, d;
        points_seen++;
        if (last_valid) begin
            r1   = coord_to_rad(longint'(last_lat));
            r2   = coord_to_rad(longint'(lat));
            dlat = (r2 - r1) >>> 1;
            dlon = (coord_to_rad(longint'(lon)) - coord_to_rad(longint'(last_lon))) >>> 1;
            rotate(r1, c1, junk);
            rotate(r2, c2, junk);
            rotate(dlat, junk, s1);
            rotate(dlon, junk, s2);
            if (s1 < 0) s1 = -s1;
            if (s2 < 0) s2 = -s2;
            c12 = (c1 * c2) >>> 30;
            t   = (c12 * s2) >>> 30;
            a   = clip(s1 * s1 + t * s2, 0, 64'sd1 << 60);
            h   = vector_angle(int_root(a), int_root((64'd1 << 60) - a));
            d   = (RADIUS_CM * 2 * h + (64'sd1 << 29)) >>> 30;
            if (d > DIST_SAT) d = DIST_SAT;
            pending_dist.push_back(d[30:0]);
        end
        last_lat   = lat;
        last_lon   = lon;
        last_valid = 1;
    endfunction

    function void check_result(logic [31:0] word);
        logic [30:0] want;
        results_seen++;
        if (pending_dist.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected distance result %0d", word[30:0]);
            return;
        end
        want = pending_dist.pop_front();
        if (word[30:0] !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("distance mismatch: expected %0d, got %0d", want, word[30:0]);
        end
    endfunction
endclass

module successive_point_great_circle_distance_tb;
    localparam int IDLE_LIMIT = 6000;
    localparam int RANDOM_POINTS = 900;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [30:0] latitude, [62:31] longitude, [63] zero
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    // [30:0] distance_cm, [31] zero
    logic [31:0] m_axis_tdata;

    distance_scoreboard sb;
    int  idle_cycles = 0;
    int  cycle_no = 0;
    bit  draining;

    successive_point_great_circle_distance dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // monitor both channels, watchdog on stalled progress
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_point(s_axis_tdata[30:0], s_axis_tdata[62:31]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (s_axis_tvalid || sb.pending_dist.size() != 0)
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // receiver stall pattern: calm windows, random stalls otherwise
    always @(posedge i_clk) begin
        if (!i_rst_n || draining || cycle_no[11])
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0) || (cycle_no[6:4] == 3'd0);
    end

    int burst_left;

    // one point request; gaps fall between random bursts
    task automatic send_point(input logic signed [30:0] lat, input logic signed [31:0] lon);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 300)) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, lon, lat};
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    // let the handshake edge pass first so the last accepted request is already noted
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_dist.size() != 0) @(posedge i_clk);
    endtask

    // half the points near the previous one, the rest in range or anywhere at all
    task automatic send_random_point();
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            lat = sb.last_lat + $signed(31'($urandom_range(0, 2000000)) - 31'sd1000000);
            lon = sb.last_lon + $signed(32'($urandom_range(0, 2000000)) - 32'sd1000000);
        end else if (kind < 8) begin
            lat = 31'($signed($urandom_range(0, 1800000000)) - 900000000);
            lon = $signed($urandom_range(0, 3600000000)) - 32'sd1800000000;
        end else begin
            lat = 31'($urandom);
            lon = 32'($urandom);
        end
        send_point(lat, lon);
    endtask

    initial begin
        sb = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        draining      = 0;
        burst_left    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first point primes only, then identical points
        send_point(31'sd0, 32'sd0);
        send_point(31'sd0, 32'sd0);
        // antipodes and coordinate extremes
        send_point(31'sd900000000, 32'sd0);
        send_point(-31'sd900000000, 32'sd0);
        send_point(31'sd0, 32'sd1800000000);
        send_point(31'sd0, -32'sd1800000000);
        send_point(31'sd0, 32'sd0);
        send_point(31'sd0, 32'sd1800000000);
        // date line crossing
        send_point(31'sd100000000, 32'sd1799000000);
        send_point(31'sd100000000, -32'sd1799000000);
        // raw field extremes beyond the valid range
        send_point(31'h3fffffff, 32'h7fffffff);
        send_point(31'h40000000, 32'h80000000);
        send_point(31'h7fffffff, 32'hffffffff);
        send_point(31'h00000001, 32'h00000001);
        send_point(31'h3fffffff, 32'h80000000);
        // tiny and repeated steps
        send_point(31'sd515000000, 32'sd1000000);
        send_point(31'sd515000001, 32'sd1000000);
        send_point(31'sd515000001, 32'sd1000000);
        send_point(-31'sd338000000, 32'sd1512000000);
        send_point(31'sd407000000, -32'sd740000000);

        // hold off until the result queue has drained
        wait_results_done();

        for (int n = 0; n < RANDOM_POINTS; n++) begin
            if (n == RANDOM_POINTS / 2)
                wait_results_done();
            send_random_point();
        end

        s_axis_tvalid <= 1'b0;
        draining = 1;
        @(posedge i_clk);
        while (sb.pending_dist.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        $display("covered %0d point requests and %0d distance results",
                 sb.points_seen, sb.results_seen);
        $display("mix of near steps, full-range points and raw field extremes");
        if (sb.mismatches == 0 && sb.pending_dist.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

`default_nettype wire
